@@ rtl/rau_pkg.sv @@
// Package for the rational accumulator unit.
// Holds opcode codes, the sequencer state type and the queue entry type.
`timescale 1ns / 1ps
package rau_pkg;
    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ADD  = 2'd1,
        OP_MUL  = 2'd2,
        OP_SIMP = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_DIVX,
        S_DIVY,
        S_MUL2,
        S_MUL3,
        S_SUM,
        S_RED,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_DONE
    } t_state;

    typedef struct packed {
        t_opcode     op;
        logic [31:0] num;
        logic [31:0] den;
    } t_cmd;
endpackage

@@ rtl/rational_accumulator_unit.sv @@
// Rational accumulator: keeps one fraction and applies load, add, multiply
// and simplify, reducing by Euclid's algorithm on a shared serial divider.
// Add uses two divisions on the divider, and reduction uses one per Euclid
// step plus two more.
// Depends on rau_pkg, rau_front, rau_exec.
`timescale 1ns / 1ps
module rational_accumulator_unit #(
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_operand_numerator,
    input  logic [31:0] i_operand_denominator,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result_numerator,
    output logic [31:0] o_result_denominator,
    output logic        o_divide_error
);
    import rau_pkg::*;
    t_cmd in_cmd, q_cmd;
    logic q_valid, q_take;

    assign in_cmd.op  = t_opcode'(i_opcode);
    assign in_cmd.num = i_operand_numerator;
    assign in_cmd.den = i_operand_denominator;

    rau_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(in_cmd), .o_valid(q_valid), .i_take(q_take), .o_cmd(q_cmd)
    );

    rau_exec #(.W(WORD_BITS)) u_exec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_cmd(q_cmd),
        .o_take(q_take), .o_valid(o_valid), .i_stall(i_stall),
        .o_num(o_result_numerator), .o_den(o_result_denominator),
        .o_err(o_divide_error)
    );
endmodule

@@ rtl/rau_divider.sv @@
// Iterative unsigned divider, one quotient bit per cycle.
// Depends on nothing; used by the rational accumulator execute unit.
`timescale 1ns / 1ps
module rau_divider #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient,
    output logic [W-1:0] o_remainder
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  r_q, r_d;
    logic [W:0]    r_r;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [W:0]    n_trial;
    logic [W:0]    n_shift;

    assign n_shift = {r_r[W-1:0], r_q[W-1]};
    assign n_trial = n_shift - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_d <= i_divisor;
            r_r <= '0;
        end else if (r_busy) begin
            if (!n_trial[W]) begin
                r_r <= n_trial;
                r_q <= {r_q[W-2:0], 1'b1};
            end else begin
                r_r <= n_shift;
                r_q <= {r_q[W-2:0], 1'b0};
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_r[W-1:0];
endmodule

@@ rtl/rau_front.sv @@
// Front end: accepts input transfers into a two-entry queue.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  rau_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_take,
    output rau_pkg::t_cmd o_cmd
);
    import rau_pkg::*;
    t_cmd        r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        n_push, n_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign n_push  = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign n_pop   = o_valid && i_take;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (n_push) r_wp <= ~r_wp;
            if (n_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, n_push} - {1'b0, n_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push) r_mem[r_wp] <= i_cmd;
    end

`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 |-> r_wp == r_rp) else $error("queue pointers differ when empty");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> r_wp == r_rp) else $error("queue pointers differ when full");
`endif
endmodule

@@ rtl/rau_exec.sv @@
// Execute unit: holds the fraction and runs each command on several
// multipliers and a shared iterative divider. Depends on rau_pkg, rau_divider.
`timescale 1ns / 1ps
module rau_exec #(
    parameter int W = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  rau_pkg::t_cmd i_cmd,
    output logic          o_take,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [31:0]   o_num,
    output logic [31:0]   o_den,
    output logic          o_err
);
    import rau_pkg::*;
    t_state       r_st, n_st;
    t_opcode      r_op;
    logic [W-1:0] r_n, r_d, r_n2, r_d2, r_t0, r_t1, r_x, r_y, r_a, r_b, r_g;
    logic         r_ov, r_err;
    logic [31:0]  r_on, r_od;
    logic         div_go, div_done;
    logic [W-1:0] div_a, div_b, div_q, div_r, sq;
    logic [W-1:0] n_sn, n_sd;
    logic [W-1:0] n_den;
    logic         neg_q;

    rau_divider #(.W(W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_go),
        .i_dividend(div_a), .i_divisor(div_b), .o_done(div_done),
        .o_quotient(div_q), .o_remainder(div_r)
    );

    function automatic logic [W-1:0] f_mag(input logic [W-1:0] v);
        f_mag = v[W-1] ? -v : v;
    endfunction

    assign n_sn = W'(signed'(i_cmd.num));
    assign n_sd = W'(signed'(i_cmd.den));
    assign n_den = r_d * r_d2;
    assign neg_q = (r_st == S_DIVX) ? (r_t0[W-1] ^ r_d[W-1]) : (r_t0[W-1] ^ r_d2[W-1]);
    assign sq = neg_q ? -div_q : div_q;

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_valid) begin
                case (i_cmd.op)
                    OP_LOAD: n_st = S_DONE;
                    OP_ADD:  n_st = (r_d == '0 || n_sd == '0) ? S_DONE : S_MUL1;
                    OP_MUL:  n_st = S_MUL1;
                    default: n_st = S_RED;
                endcase
            end
            S_MUL1: n_st = (r_op == OP_ADD) ? S_DIVX : S_RED;
            S_DIVX: if (div_done) n_st = S_DIVY;
            S_DIVY: if (div_done) n_st = S_MUL2;
            S_MUL2: n_st = S_MUL3;
            S_MUL3: n_st = S_SUM;
            S_SUM:  n_st = S_RED;
            S_RED:  n_st = (($signed(r_n) < $signed(r_d) ? r_n : r_d) == '0 ||
                            ($signed(r_n) < $signed(r_d) ? r_n[W-1] : r_d[W-1]))
                           ? S_DONE : S_GCD;
            S_GCD:  if (div_done && div_r == '0) n_st = S_DIVN;
            S_DIVN: if (div_done) n_st = S_DIVD;
            S_DIVD: if (div_done) n_st = S_DONE;
            S_DONE: if (!r_ov || !i_stall) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_comb begin
        o_take = (r_st == S_IDLE);
        div_go = 1'b0;
        div_a  = r_a;
        div_b  = r_b;
        case (r_st)
            S_MUL1: if (r_op == OP_ADD) begin
                div_go = 1'b1;
                div_a  = f_mag(n_den);
                div_b  = f_mag(r_d);
            end
            S_DIVX: if (div_done) begin
                div_go = 1'b1;
                div_a  = f_mag(r_t0);
                div_b  = f_mag(r_d2);
            end
            S_RED: begin
                div_go = 1'b1;
                div_a  = r_n;
                div_b  = r_d;
            end
            S_GCD: if (div_done) begin
                div_go = 1'b1;
                if (div_r == '0) begin
                    div_a = r_n;
                    div_b = r_b;
                end else begin
                    div_a = r_b;
                    div_b = div_r;
                end
            end
            S_DIVN: if (div_done) begin
                div_go = 1'b1;
                div_a  = r_d;
                div_b  = r_g;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_n  <= '0;
            r_d  <= W'(1);
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == S_DONE && (!r_ov || !i_stall)) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: if (i_valid) begin
                    r_op  <= i_cmd.op;
                    r_n2  <= n_sn;
                    r_d2  <= n_sd;
                    r_err <= 1'b0;
                    case (i_cmd.op)
                        OP_LOAD: begin
                            r_n <= n_sn;
                            r_d <= n_sd;
                        end
                        OP_ADD:  if (r_d == '0 || n_sd == '0) r_err <= 1'b1;
                        default: ;
                    endcase
                end
                S_MUL1: begin
                    if (r_op == OP_ADD) r_t0 <= n_den;
                    else begin
                        r_n <= r_n * r_n2;
                        r_d <= n_den;
                    end
                end
                S_DIVX: if (div_done) r_x <= sq;
                S_DIVY: if (div_done) r_y <= sq;
                S_MUL2: r_t1 <= r_x * r_n;
                S_MUL3: r_x <= r_y * r_n2;
                S_SUM: begin
                    r_n <= r_t1 + r_x;
                    r_d <= r_t0;
                end
                S_GCD: if (div_done) begin
                    if (div_r == '0) r_g <= r_b;
                end
                S_DIVN: if (div_done) r_n <= div_q;
                S_DIVD: if (div_done) r_d <= div_q;
                S_DONE: if (!r_ov || !i_stall) begin
                    r_on <= 32'($signed(r_n));
                    r_od <= 32'($signed(r_d));
                end
                default: ;
            endcase
            if (div_go) r_b <= div_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_DONE && (!r_ov || !i_stall)) o_err <= r_err;
    end

    assign r_a     = r_n;
    assign o_valid = r_ov;
    assign o_num   = r_on;
    assign o_den   = r_od;

`ifndef SYNTHESIS
    a_add_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_SUM |-> !r_err) else $error("error set on completed add");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_IDLE |-> !div_go) else $error("divider started while idle");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && i_stall |=> r_ov && $stable(r_on)) else $error("result lost");
`endif
endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for rational_accumulator_unit: a fraction predictor
// in a small scoreboard class, with directed and random stimulus and random stalls.
// Depends on rau_pkg and the rational_accumulator_unit RTL.
`timescale 1ns / 1ps
module testbench;
    import rau_pkg::*;

    localparam int NUM_RANDOM = 1100;
    localparam int IDLE_LIMIT = 50000;
    localparam int MIN_INT = 32'sh8000_0000;
    localparam int MAX_INT = 32'sh7fff_ffff;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = OP_LOAD;
    logic [31:0] i_operand_numerator = '0;
    logic [31:0] i_operand_denominator = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_result_numerator;
    logic [31:0] o_result_denominator;
    logic        o_divide_error;

    logic sending_done = 1'b0;
    logic hold_request = 1'b0;
    int   idle_cycles = 0;

    rational_accumulator_unit dut (.*);

    always #5 i_clk = ~i_clk;

    class fraction_scoreboard;
        int frac_num;
        int frac_den;
        int mismatches;
        int exp_num[$];
        int exp_den[$];
        bit exp_err[$];

        function new();
            frac_num = 0;
            frac_den = 1;
            mismatches = 0;
        endfunction

        function int quot_wrap(int a, int b);
            longint q;
            q = longint'(a) / longint'(b);
            return int'(q);
        endfunction

        function int gcd(int a, int b);
            int t;
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            return a;
        endfunction

        function void reduce_fraction();
            int lo;
            int g;
            lo = (frac_num < frac_den) ? frac_num : frac_den;
            if (lo <= 0) return;
            g = gcd(frac_num, frac_den);
            frac_num = frac_num / g;
            frac_den = frac_den / g;
        endfunction

        function void note_input(t_opcode op, int n, int d);
            int den;
            int x;
            int y;
            bit err;
            err = 1'b0;
            case (op)
                OP_LOAD: begin
                    frac_num = n;
                    frac_den = d;
                end
                OP_ADD: begin
                    if (frac_den == 0 || d == 0) begin
                        err = 1'b1;
                    end else begin
                        den = frac_den * d;
                        x = quot_wrap(den, frac_den);
                        y = quot_wrap(den, d);
                        frac_num = x * frac_num + y * n;
                        frac_den = den;
                        reduce_fraction();
                    end
                end
                OP_MUL: begin
                    frac_num = frac_num * n;
                    frac_den = frac_den * d;
                    reduce_fraction();
                end
                default: begin
                    reduce_fraction();
                end
            endcase
            exp_num.push_back(frac_num);
            exp_den.push_back(frac_den);
            exp_err.push_back(err);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(int n, int d, bit e);
            int wn;
            int wd;
            bit we;
            if (exp_num.size() == 0) begin
                report($sformatf("unexpected result %0d/%0d err=%0b", n, d, e));
                return;
            end
            wn = exp_num.pop_front();
            wd = exp_den.pop_front();
            we = exp_err.pop_front();
            if (n !== wn) report($sformatf("numerator %0d, want %0d", n, wn));
            if (d !== wd) report($sformatf("denominator %0d, want %0d", d, wd));
            if (e !== we) report($sformatf("divide_error %0b, want %0b", e, we));
        endtask

        function int pending();
            return exp_num.size();
        endfunction
    endclass

    fraction_scoreboard sb = new();

    task automatic send_item(t_opcode op, int n, int d, bit may_idle);
        i_valid <= 1'b1;
        i_opcode <= op;
        i_operand_numerator <= n;
        i_operand_denominator <= d;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        sb.note_input(op, n, d);
        if (may_idle && $urandom_range(0, 99) < 37) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic int rand_operand();
        int v;
        case ($urandom_range(0, 9))
            0, 1: v = $urandom;
            2: v = $urandom_range(0, 1) ? MIN_INT : MAX_INT;
            default: v = $urandom_range(0, 60);
        endcase
        if ($urandom_range(0, 3) == 0) v = -v;
        return v;
    endfunction

    initial begin
        t_opcode op;
        int      d;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(OP_LOAD, MAX_INT, MIN_INT, 1'b1);
        send_item(OP_SIMP, 0, 0, 1'b1);
        send_item(OP_LOAD, 12, -18, 1'b1);
        send_item(OP_SIMP, 7, 7, 1'b1);
        send_item(OP_LOAD, 12, 18, 1'b1);
        send_item(OP_SIMP, -1, -1, 1'b1);
        send_item(OP_ADD, 1, 6, 1'b1);
        send_item(OP_MUL, -3, 4, 1'b1);
        send_item(OP_LOAD, 5, 0, 1'b1);
        send_item(OP_ADD, 1, 2, 1'b1);
        send_item(OP_LOAD, 1, 2, 1'b1);
        send_item(OP_ADD, 3, 0, 1'b1);
        send_item(OP_LOAD, 0, 5, 1'b1);
        send_item(OP_SIMP, 0, 0, 1'b1);
        send_item(OP_LOAD, 1, MIN_INT, 1'b1);
        send_item(OP_ADD, 1, -1, 1'b1);
        send_item(OP_MUL, MIN_INT, -1, 1'b1);
        send_item(OP_LOAD, MAX_INT, MAX_INT, 1'b1);
        send_item(OP_SIMP, 0, 0, 1'b1);
        send_item(OP_MUL, MAX_INT, MIN_INT, 1'b1);
        send_item(OP_ADD, -1, -1, 1'b1);
        send_item(OP_LOAD, 21, 34, 1'b1);
        send_item(OP_SIMP, 0, 0, 1'b1);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i == 600) hold_request <= 1'b1;
            op = t_opcode'($urandom_range(0, 3));
            d = rand_operand();
            if (op == OP_ADD && $urandom_range(0, 19) == 0) d = 0;
            send_item(op, rand_operand(), d, !(i >= 300 && i < 500));
        end
        i_valid <= 1'b0;
        sending_done <= 1'b1;
    end

    initial begin
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall)
                sb.check_result(o_result_numerator, o_result_denominator, o_divide_error);
            if (hold_request && !hold_used) begin
                hold_used = 1'b1;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (idle_cycles >= 0 && ($time / 10) % 4000 < 1500) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < 37);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        wait (sending_done);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
